### rtl/key_press_event_detector_assert.svh
// Assertion macros shared by the key press event detector RTL.
`ifndef KEY_PRESS_EVENT_DETECTOR_ASSERT_SVH
`define KEY_PRESS_EVENT_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define KPED_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define KPED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/kped_pkg.sv
// Shared types and constants for the key press event detector.
`timescale 1ns / 1ps
package kped_pkg;

  localparam logic [1:0] IDLE_WORD = 2'b11;

  localparam logic [7:0]  DEBOUNCE_RST = 8'd1;
  localparam logic [15:0] LONG_RST     = 16'd300;
  localparam logic [15:0] WINDOW_RST   = 16'd50;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_DOOR_CLICK  = 3'd1,
    EV_DOOR_LONG   = 3'd2,
    EV_DOOR_DOUBLE = 3'd3,
    EV_RESET_LONG  = 3'd4
  } ev_t;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_LONG     = 2'd1,
    CFG_WINDOW   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] long_press_ticks;
    logic [15:0] double_window_ticks;
  } cfg_t;

  // Debounce result for one beat.
  typedef struct packed {
    logic       accept;   // a new key word was taken this beat
    logic       steady;   // raw word equals the accepted word
    logic [1:0] keys;     // accepted word after this beat
  } deb_t;

endpackage

### rtl/kped_debounce.sv
// Debounce filter for the two-bit raw key word.
`timescale 1ns / 1ps
module kped_debounce import kped_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [1:0] word,
  input  logic [7:0] debounce_ticks,
  output deb_t       deb
);

  logic [1:0] acc_r, acc_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [8:0] cnt_inc;

  // Count differing beats; accept once the count passes the limit
  always_comb begin
    cnt_inc    = {1'b0, cnt_r} + 9'd1;
    acc_nxt    = acc_r;
    cnt_nxt    = 8'd0;
    deb.accept = 1'b0;
    deb.steady = (word == acc_r);
    if (!deb.steady) begin
      if (cnt_inc > {1'b0, debounce_ticks}) begin
        acc_nxt    = word;
        deb.accept = 1'b1;
      end else begin
        cnt_nxt = cnt_inc[7:0];
      end
    end
    deb.keys = acc_nxt;
  end

  // Advance on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 2'b00;
      cnt_r <= 8'd0;
    end else if (step) begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/kped_events.sv
// Press tracking: hold counter, edge counter and double click window.
`timescale 1ns / 1ps
module kped_events import kped_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [1:0] word,
  input  deb_t       deb,
  input  cfg_t       cfg,
  output ev_t        ev
);

`include "key_press_event_detector_assert.svh"

  logic        press_r, press_nxt;
  logic [15:0] hold_r, hold_nxt;
  logic [1:0]  edges_r, edges_nxt;
  logic [15:0] dcnt_r, dcnt_nxt;
  logic [16:0] dcnt_inc;
  logic [1:0]  edges_mid;

  // Press start/end and long press detection
  always_comb begin
    press_nxt = press_r;
    hold_nxt  = hold_r;
    edges_mid = edges_r;
    ev        = EV_NONE;
    if (deb.accept) begin
      if (deb.keys == IDLE_WORD) begin
        press_nxt = 1'b0;
        hold_nxt  = 16'd0;
      end else begin
        press_nxt = 1'b1;
        if (edges_r != 2'd3) begin
          edges_mid = edges_r + 2'd1;
        end
        if (!deb.keys[0]) begin
          ev = EV_DOOR_CLICK;
        end
      end
    end else if (deb.steady && press_r && (hold_r != 16'hFFFF)) begin
      hold_nxt = hold_r + 16'd1;
      if (hold_nxt == cfg.long_press_ticks) begin
        if (!word[1]) begin
          ev = EV_RESET_LONG;
        end else if (!word[0]) begin
          ev = EV_DOOR_LONG;
        end
      end
    end

    // Double click window; a repeat press inside the window overrides a click
    dcnt_inc  = {1'b0, dcnt_r} + 17'd1;
    edges_nxt = edges_mid;
    dcnt_nxt  = dcnt_r;
    if (edges_mid != 2'd0) begin
      if (dcnt_inc > {1'b0, cfg.double_window_ticks}) begin
        dcnt_nxt  = 16'd0;
        edges_nxt = 2'd0;
      end else if (edges_mid > 2'd1) begin
        dcnt_nxt  = 16'd0;
        edges_nxt = 2'd0;
        if (!word[0]) begin
          ev = EV_DOOR_DOUBLE;
        end
      end else begin
        dcnt_nxt = dcnt_inc[15:0];
      end
    end
  end

  // Advance on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_r <= 1'b0;
      hold_r  <= 16'd0;
      edges_r <= 2'd0;
      dcnt_r  <= 16'd0;
    end else if (step) begin
      press_r <= press_nxt;
      hold_r  <= hold_nxt;
      edges_r <= edges_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

  `KPED_ASSERT_NOW(a_hold_needs_press, clk, rst_n, hold_r != 16'd0, press_r)
  `KPED_ASSERT_NOW(a_edges_below_two, clk, rst_n, 1'b1, edges_r < 2'd2)
  `KPED_ASSERT_NOW(a_window_idle, clk, rst_n, edges_r == 2'd0, dcnt_r == 16'd0)

endmodule

### rtl/key_press_event_detector.sv
// Top level of the key press event detector.
`timescale 1ns / 1ps
// Takes one beat per timer tick holding the raw active-low door and reset key
// levels and returns exactly one result beat per input beat: the detected key
// event and the debounced key word. All per-beat work is one pass of counter
// and compare logic ahead of a single output register, so a new beat is taken
// every cycle and its result is registered; the input side keeps moving while the
// output register is empty or being drained in the same cycle. Configuration
// writes land at once and take effect on the next beat.
module key_press_event_detector import kped_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_door_key_level,
  input  logic        in_reset_key_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_key_event,
  output logic [1:0]  out_stable_keys,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

`include "key_press_event_detector_assert.svh"

  cfg_t       cfg_r;
  logic       step;
  logic [1:0] word;
  deb_t       deb;
  ev_t        ev;
  logic       out_valid_r;
  logic [2:0] key_event_r;
  logic [1:0] stable_keys_r;

  assign word     = {in_reset_key_level, in_door_key_level};
  assign in_ready = !out_valid_r || out_ready;
  assign step     = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks      <= DEBOUNCE_RST;
      cfg_r.long_press_ticks    <= LONG_RST;
      cfg_r.double_window_ticks <= WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE: cfg_r.debounce_ticks      <= cfg_wdata[7:0];
        CFG_LONG:     cfg_r.long_press_ticks    <= cfg_wdata;
        CFG_WINDOW:   cfg_r.double_window_ticks <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  kped_debounce u_debounce (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .word           (word),
    .debounce_ticks (cfg_r.debounce_ticks),
    .deb            (deb)
  );

  kped_events u_events (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .word  (word),
    .deb   (deb),
    .cfg   (cfg_r),
    .ev    (ev)
  );

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      key_event_r   <= ev;
      stable_keys_r <= deb.keys;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_key_event   = key_event_r;
  assign out_stable_keys = stable_keys_r;

  `KPED_ASSERT_NEXT(a_accept_loads_out, clk, rst_n, step, out_valid_r)
  `KPED_ASSERT_NOW(a_click_door_down, clk, rst_n, out_valid_r && (key_event_r == EV_DOOR_CLICK), !stable_keys_r[0])
  `KPED_ASSERT_NOW(a_rlong_reset_down, clk, rst_n, out_valid_r && (key_event_r == EV_RESET_LONG), !stable_keys_r[1])

endmodule

### tb/key_press_event_detector_test.sv
// Self-checking testbench for the key press event detector.
`timescale 1ns / 1ps
module key_press_event_detector_test import kped_pkg::*; ();

  // One predicted result beat.
  typedef struct {
    ev_t        key_event;
    logic [1:0] stable_keys;
  } key_result_t;

  // Tracks detector state and queues the result each input beat should produce.
  class key_event_scoreboard;
    logic [7:0]  deb_ticks  = DEBOUNCE_RST;
    logic [15:0] long_ticks = LONG_RST;
    logic [15:0] win_ticks  = WINDOW_RST;

    logic [1:0]  stable_word = 2'b00;
    logic [7:0]  settle_cnt  = 8'd0;
    bit          pressed     = 1'b0;
    logic [15:0] held_cnt    = 16'd0;
    logic [1:0]  edge_cnt    = 2'd0;
    logic [15:0] window_cnt  = 16'd0;

    key_result_t expected_events[$];
    int unsigned errors = 0;

    task report_mismatch(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_config(logic [7:0] deb, logic [15:0] lng, logic [15:0] win);
      deb_ticks  = deb;
      long_ticks = lng;
      win_ticks  = win;
    endfunction

    // Advance the predicted state by one accepted tick.
    function void take_key_sample(bit door_level, bit reset_level);
      logic [1:0]  word;
      logic [8:0]  settle_next;
      logic [16:0] window_next;
      key_result_t res;
      word = {reset_level, door_level};
      res.key_event = EV_NONE;

      // Debounce and press tracking
      if (word != stable_word) begin
        settle_next = {1'b0, settle_cnt} + 9'd1;
        if (settle_next > {1'b0, deb_ticks}) begin
          settle_cnt  = 8'd0;
          stable_word = word;
          if (word == IDLE_WORD) begin
            pressed  = 1'b0;
            held_cnt = 16'd0;
          end else begin
            pressed = 1'b1;
            if (edge_cnt != 2'd3) edge_cnt++;
            if (!word[0]) res.key_event = EV_DOOR_CLICK;
          end
        end else begin
          settle_cnt = settle_next[7:0];
        end
      end else begin
        if (pressed && held_cnt != 16'hFFFF) begin
          held_cnt++;
          if (held_cnt == long_ticks) begin
            if (!word[1]) res.key_event = EV_RESET_LONG;
            else if (!word[0]) res.key_event = EV_DOOR_LONG;
          end
        end
        settle_cnt = 8'd0;
      end

      // Double click window
      if (edge_cnt != 2'd0) begin
        window_next = {1'b0, window_cnt} + 17'd1;
        if (window_next > {1'b0, win_ticks}) begin
          window_cnt = 16'd0;
          edge_cnt   = 2'd0;
        end else if (edge_cnt > 2'd1) begin
          window_cnt = 16'd0;
          edge_cnt   = 2'd0;
          if (!word[0]) res.key_event = EV_DOOR_DOUBLE;
        end else begin
          window_cnt = window_next[15:0];
        end
      end

      res.stable_keys = stable_word;
      expected_events.push_back(res);
    endfunction

    // Compare one result beat against the oldest prediction.
    task check_key_result(logic [2:0] key_event, logic [1:0] stable_keys);
      key_result_t want;
      if (expected_events.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_events.pop_front();
        if (key_event !== want.key_event)
          report_mismatch($sformatf("key_event got %0d want %0d",
                                    key_event, want.key_event));
        if (stable_keys !== want.stable_keys)
          report_mismatch($sformatf("stable_keys got %0d want %0d",
                                    stable_keys, want.stable_keys));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_door_key_level;
  logic        in_reset_key_level;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_key_event;
  logic [1:0]  out_stable_keys;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  bit in_idle_on;
  bit out_idle_on;
  key_event_scoreboard sb;

  key_press_event_detector u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_door_key_level  (in_door_key_level),
    .in_reset_key_level (in_reset_key_level),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_key_event      (out_key_event),
    .out_stable_keys    (out_stable_keys),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Send one tick and wait for its handshake.
  task automatic send_beat(bit door_level, bit reset_level);
    int unsigned gap;
    gap = in_idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_door_key_level  <= door_level;
    in_reset_key_level <= reset_level;
    do @(posedge clk); while (!in_ready);
    sb.take_key_sample(door_level, reset_level);
  endtask

  // Hold one key word for a number of ticks.
  task automatic send_run(logic [1:0] word, int unsigned len);
    repeat (len) send_beat(word[0], word[1]);
  endtask

  // Drain outstanding results, then write all three registers.
  task automatic apply_config(logic [7:0] deb, logic [15:0] lng, logic [15:0] win);
    in_valid <= 1'b0;
    while (sb.expected_events.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_wdata <= {8'd0, deb};
    @(posedge clk);
    cfg_index <= CFG_LONG;
    cfg_wdata <= lng;
    @(posedge clk);
    cfg_index <= CFG_WINDOW;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_config(deb, lng, win);
  endtask

  // Mostly press and release runs sized around the current limits, some noise.
  task automatic random_phase(int unsigned budget);
    int unsigned sent;
    int unsigned len;
    logic [1:0]  word;
    sent = 0;
    while (sent < budget) begin
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, 4);
        repeat (len) send_beat(1'($urandom), 1'($urandom));
      end else begin
        word = ($urandom_range(0, 4) < 2) ? IDLE_WORD : 2'($urandom_range(0, 2));
        case ($urandom_range(0, 3))
          0: len = (sb.deb_ticks == 0) ? 1 : $urandom_range(1, sb.deb_ticks);
          1, 2: len = sb.deb_ticks + 1 + $urandom_range(0, 4);
          default: len = sb.deb_ticks + ((sb.long_ticks < 64) ? sb.long_ticks : 8)
                         + $urandom_range(0, 3);
        endcase
        send_run(word, len);
      end
      sent += len;
    end
  endtask

  // Result side: stall at random, check every beat taken.
  initial begin
    int unsigned gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = out_idle_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_key_result(out_key_event, out_stable_keys);
    end
  end

  // Stimulus
  initial begin
    sb                 = new;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_door_key_level  = 1'b1;
    in_reset_key_level = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = CFG_DEBOUNCE;
    cfg_wdata          = 16'd0;
    in_idle_on         = 1'b1;
    out_idle_on        = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: release from the reset word, click, double, glitch, press to press
    send_run(IDLE_WORD, 3);
    send_run(2'b10, 3);
    send_run(IDLE_WORD, 3);
    send_run(2'b10, 3);
    send_run(IDLE_WORD, 2);
    send_run(2'b01, 1);
    send_run(IDLE_WORD, 1);
    send_run(2'b01, 3);
    send_run(2'b00, 3);
    send_run(IDLE_WORD, 3);

    // Minimum debounce and window limits
    apply_config(8'd0, 16'd1, 16'd0);
    random_phase(50);

    apply_config(8'd2, 16'd8, 16'd20);
    random_phase(60);
    send_run(IDLE_WORD, 4);

    // Longest debounce: press taken on its 256th tick, then held into a long press
    apply_config(8'd255, 16'd5, 16'hFFFF);
    send_run(2'b10, 256);
    send_run(2'b10, 6);

    // A zero long limit never reports a long press
    apply_config(8'd1, 16'd0, 16'd10);
    random_phase(40);

    // Bulk random at small limits
    apply_config(8'd3, 16'd12, 16'd30);
    random_phase(60);

    // Drain and finish
    in_valid <= 1'b0;
    while (sb.expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog
  initial begin
    #200000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
